// ===== rtl/otq_pkg.sv =====
`timescale 1ns / 1ps
package otq_pkg;

  localparam int MAX_TIMERS = 16;
  localparam int ADDR_W     = $clog2(MAX_TIMERS);
  localparam int CNT_W      = $clog2(MAX_TIMERS + 1);

  // request codes
  localparam logic [1:0] REQ_TICK       = 2'd0;
  localparam logic [1:0] REQ_SCHEDULE   = 2'd1;
  localparam logic [1:0] REQ_CANCEL     = 2'd2;
  localparam logic [1:0] REQ_CANCEL_ALL = 2'd3;

  // result kinds
  localparam logic [1:0] RK_EXPIRED  = 2'd0;
  localparam logic [1:0] RK_SCHEDULE = 2'd1;
  localparam logic [1:0] RK_CANCEL   = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  // one queue entry, stored in expiry order
  typedef struct packed {
    logic [7:0]  owner;
    logic [2:0]  kind;
    logic [7:0]  resource;
    logic [31:0] remaining;
  } entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [7:0]  owner;
    logic [2:0]  tkind;
    logic [7:0]  resource;
    logic [4:0]  removed;
    logic        last;
  } result_t;

endpackage

// ===== rtl/otq_ram.sv =====
`timescale 1ns / 1ps
module otq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ordered_timer_queue_core.sv =====
`timescale 1ns / 1ps
// Ordered timer queue: up to 16 timeouts kept in one RAM sorted by expiry,
// equal expiries in insertion order. A transaction is taken when start is high
// and busy is low. Each request walks the occupied RAM entries at most once
// through the single read port and compacts or shifts them through the write
// port. Busy stays high while a tick, cancel or cancel-all sweeps every entry
// held or a schedule walks down to the new entry's place (less far when it
// lands near the tail); a schedule into a full queue answers in the next
// cycle without raising busy. Results appear one per cycle, result_valid
// high for exactly one cycle; the receiver cannot stall them, and last marks
// the final result of a request. A tick with nothing expiring gives no result.
module ordered_timer_queue_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [7:0]  owner_id,
  input  logic [2:0]  timeout_kind,
  input  logic [7:0]  resource_id,
  input  logic [31:0] delay_ticks,
  input  logic        lock_kind_we,
  input  logic [2:0]  lock_kind_wdata,
  output logic        result_valid,
  output logic [1:0]  result_kind,
  output logic [1:0]  status,
  output logic [7:0]  out_owner,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_resource,
  output logic [4:0]  removed_count,
  output logic        last
);

  localparam int AW = otq_pkg::ADDR_W;
  localparam int CW = otq_pkg::CNT_W;

  otq_pkg::state_t state, state_next;

  logic [2:0]    lock_kind;
  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] rd, rd_next;
  logic [CW-1:0] wr, wr_next;
  logic [AW-1:0] pos, pos_next;
  logic          dv, dv_next;
  logic          found, found_next;
  logic [4:0]    removed, removed_next;
  logic          pend_v, pend_v_next;
  otq_pkg::entry_t pend, pend_next;

  logic [1:0]  rq_type;
  logic [7:0]  rq_owner;
  logic [2:0]  rq_kind;
  logic [7:0]  rq_res;
  logic [31:0] rq_delay;
  logic        accept;

  logic            re, we;
  logic [AW-1:0]   raddr, waddr;
  otq_pkg::entry_t rdata, wdata, rdata_q;
  logic            res_v, res_v_next;
  otq_pkg::result_t res, res_next;

  logic        issue, finish, match, ins_now;
  logic [31:0] dec;

  assign accept = start && !busy;
  assign busy   = (state == otq_pkg::S_RUN);
  assign rdata  = rdata_q;

  otq_ram #(
    .WIDTH($bits(otq_pkg::entry_t)),
    .DEPTH(otq_pkg::MAX_TIMERS)
  ) u_ram (
    .clk  (clk),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata_q),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata)
  );

  // per-entry decisions on the data coming back from the RAM
  assign dec     = rdata.remaining - 32'd1;
  assign match   = (rdata.owner == rq_owner) && (rdata.kind == rq_kind) &&
                   !((rq_kind == lock_kind) && (rdata.resource != rq_res));
  assign ins_now = dv && !(rdata.remaining > rq_delay);
  assign issue   = (rq_type == otq_pkg::REQ_SCHEDULE) ? (rd != '0) : (rd < cnt);
  assign finish  = (rq_type == otq_pkg::REQ_SCHEDULE) ? (ins_now || (!dv && rd == '0))
                                                      : (!dv && !issue);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      otq_pkg::S_IDLE: begin
        if (accept && !(req_type == otq_pkg::REQ_SCHEDULE &&
                        cnt == CW'(otq_pkg::MAX_TIMERS))) begin
          state_next = otq_pkg::S_RUN;
        end
      end
      otq_pkg::S_RUN: begin
        if (finish) begin
          state_next = otq_pkg::S_IDLE;
        end
      end
      default: state_next = otq_pkg::S_IDLE;
    endcase
  end

  // sweep datapath, ram access and results
  always_comb begin
    cnt_next     = cnt;
    rd_next      = rd;
    wr_next      = wr;
    pos_next     = pos;
    dv_next      = 1'b0;
    found_next   = found;
    removed_next = removed;
    pend_v_next  = pend_v;
    pend_next    = pend;
    re           = 1'b0;
    raddr        = '0;
    we           = 1'b0;
    waddr        = '0;
    wdata        = rdata;
    res_v_next   = 1'b0;
    res_next     = '0;
    case (state)
      otq_pkg::S_IDLE: begin
        if (accept) begin
          rd_next      = (req_type == otq_pkg::REQ_SCHEDULE) ? cnt : '0;
          wr_next      = '0;
          found_next   = 1'b0;
          removed_next = '0;
          pend_v_next  = 1'b0;
          if (req_type == otq_pkg::REQ_SCHEDULE && cnt == CW'(otq_pkg::MAX_TIMERS)) begin
            res_v_next      = 1'b1;
            res_next.kind   = otq_pkg::RK_SCHEDULE;
            res_next.status = otq_pkg::ST_FULL;
            res_next.last   = 1'b1;
          end
        end
      end
      otq_pkg::S_RUN: begin
        if (rq_type == otq_pkg::REQ_SCHEDULE) begin
          // walk down from the tail, shifting later expiries up by one
          if (issue && !ins_now) begin
            re      = 1'b1;
            raddr   = AW'(rd - CW'(1));
            rd_next = rd - CW'(1);
            pos_next = AW'(rd - CW'(1));
            dv_next = 1'b1;
          end
          if (dv) begin
            we    = 1'b1;
            waddr = pos + AW'(1);
            if (ins_now) begin
              wdata = '{owner: rq_owner, kind: rq_kind, resource: rq_res,
                        remaining: rq_delay};
            end else begin
              wdata = rdata;
            end
          end else if (finish) begin
            we    = 1'b1;
            waddr = '0;
            wdata = '{owner: rq_owner, kind: rq_kind, resource: rq_res,
                      remaining: rq_delay};
          end
          if (finish) begin
            cnt_next        = cnt + CW'(1);
            res_v_next      = 1'b1;
            res_next.kind   = otq_pkg::RK_SCHEDULE;
            res_next.status = otq_pkg::ST_OK;
            res_next.last   = 1'b1;
          end
        end else begin
          // walk up from the head, compacting kept entries
          if (issue) begin
            re       = 1'b1;
            raddr    = AW'(rd);
            rd_next  = rd + CW'(1);
            pos_next = AW'(rd);
            dv_next  = 1'b1;
          end
          if (dv) begin
            case (rq_type)
              otq_pkg::REQ_TICK: begin
                if (dec == '0) begin
                  if (pend_v) begin
                    res_v_next        = 1'b1;
                    res_next.kind     = otq_pkg::RK_EXPIRED;
                    res_next.owner    = pend.owner;
                    res_next.tkind    = pend.kind;
                    res_next.resource = pend.resource;
                  end
                  pend_v_next = 1'b1;
                  pend_next   = rdata;
                end else begin
                  we              = 1'b1;
                  waddr           = AW'(wr);
                  wdata.remaining = dec;
                  wr_next         = wr + CW'(1);
                  if (pend_v) begin
                    res_v_next        = 1'b1;
                    res_next.kind     = otq_pkg::RK_EXPIRED;
                    res_next.owner    = pend.owner;
                    res_next.tkind    = pend.kind;
                    res_next.resource = pend.resource;
                    res_next.last     = 1'b1;
                    pend_v_next       = 1'b0;
                  end
                end
              end
              otq_pkg::REQ_CANCEL: begin
                if (match && !found) begin
                  found_next = 1'b1;
                end else begin
                  we      = 1'b1;
                  waddr   = AW'(wr);
                  wr_next = wr + CW'(1);
                end
              end
              default: begin
                if (rdata.owner == rq_owner) begin
                  removed_next = removed + 5'd1;
                end else begin
                  we      = 1'b1;
                  waddr   = AW'(wr);
                  wr_next = wr + CW'(1);
                end
              end
            endcase
          end
          if (finish) begin
            cnt_next = wr;
            case (rq_type)
              otq_pkg::REQ_TICK: begin
                if (pend_v) begin
                  res_v_next        = 1'b1;
                  res_next.kind     = otq_pkg::RK_EXPIRED;
                  res_next.owner    = pend.owner;
                  res_next.tkind    = pend.kind;
                  res_next.resource = pend.resource;
                  res_next.last     = 1'b1;
                  pend_v_next       = 1'b0;
                end
              end
              otq_pkg::REQ_CANCEL: begin
                res_v_next       = 1'b1;
                res_next.kind    = otq_pkg::RK_CANCEL;
                res_next.status  = found ? otq_pkg::ST_OK : otq_pkg::ST_NOT_FOUND;
                res_next.removed = found ? 5'd1 : 5'd0;
                res_next.last    = 1'b1;
              end
              default: begin
                res_v_next       = 1'b1;
                res_next.kind    = otq_pkg::RK_CANCEL;
                res_next.status  = (removed != '0) ? otq_pkg::ST_OK
                                                   : otq_pkg::ST_NOT_FOUND;
                res_next.removed = removed;
                res_next.last    = 1'b1;
              end
            endcase
          end
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= otq_pkg::S_IDLE;
      cnt       <= '0;
      dv        <= 1'b0;
      pend_v    <= 1'b0;
      res_v     <= 1'b0;
      lock_kind <= 3'd1;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      dv     <= dv_next;
      pend_v <= pend_v_next;
      res_v  <= res_v_next;
      if (lock_kind_we) begin
        lock_kind <= lock_kind_wdata;
      end
    end
  end

  // sweep and payload registers
  always_ff @(posedge clk) begin
    rd      <= rd_next;
    wr      <= wr_next;
    pos     <= pos_next;
    found   <= found_next;
    removed <= removed_next;
    pend    <= pend_next;
    res     <= res_next;
    if (accept) begin
      rq_type  <= req_type;
      rq_owner <= owner_id;
      rq_kind  <= timeout_kind;
      rq_res   <= resource_id;
      rq_delay <= (delay_ticks == '0) ? 32'd1 : delay_ticks;
    end
  end

  assign result_valid  = res_v;
  assign result_kind   = res.kind;
  assign status        = res.status;
  assign out_owner     = res.owner;
  assign out_kind      = res.tkind;
  assign out_resource  = res.resource;
  assign removed_count = res.removed;
  assign last          = res.last;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(otq_pkg::MAX_TIMERS))
    else $error("entry count above capacity");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    res_v && (res.kind != otq_pkg::RK_EXPIRED) |-> res.last)
    else $error("status result without last");

  a_run_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept && (req_type != otq_pkg::REQ_SCHEDULE) |=> busy)
    else $error("request accepted without a sweep");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  localparam int SLOTS       = otq_pkg::MAX_TIMERS;
  localparam int STALL_LIMIT = 2000;

  // directed stimulus row, with an optional typed-in answer
  typedef struct {
    logic [1:0]       req;
    logic [7:0]       owner;
    logic [2:0]       kind;
    logic [7:0]       res;
    logic [31:0]      delay;
    bit               typed;
    otq_pkg::result_t answer;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  req_type = otq_pkg::REQ_TICK;
  logic [7:0]  owner_id = '0;
  logic [2:0]  timeout_kind = '0;
  logic [7:0]  resource_id = '0;
  logic [31:0] delay_ticks = '0;
  logic        lock_kind_we = 1'b0;
  logic [2:0]  lock_kind_wdata = '0;
  logic        result_valid;
  logic [1:0]  result_kind;
  logic [1:0]  status;
  logic [7:0]  out_owner;
  logic [2:0]  out_kind;
  logic [7:0]  out_resource;
  logic [4:0]  removed_count;
  logic        last;

  // typed answer travelling with the current transaction
  bit               pin_answer = 1'b0;
  otq_pkg::result_t pinned = '0;

  ordered_timer_queue_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .owner_id(owner_id), .timeout_kind(timeout_kind),
    .resource_id(resource_id), .delay_ticks(delay_ticks),
    .lock_kind_we(lock_kind_we), .lock_kind_wdata(lock_kind_wdata),
    .result_valid(result_valid), .result_kind(result_kind), .status(status),
    .out_owner(out_owner), .out_kind(out_kind), .out_resource(out_resource),
    .removed_count(removed_count), .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the timer queue
  bit          q_valid [SLOTS];
  logic [7:0]  q_owner [SLOTS];
  logic [2:0]  q_kind [SLOTS];
  logic [7:0]  q_res [SLOTS];
  logic [31:0] q_left [SLOTS];
  int          q_rank [SLOTS];
  logic [2:0]  lock_code = 3'd1;

  otq_pkg::result_t pending_q[$];
  int      errors = 0;
  int      n_items = 0;
  int      n_results = 0;
  int      n_expired = 0;
  int      n_full = 0;

  // free a slot and close its gap in the expiry ranking
  task automatic drop_timer(int i);
    q_valid[i] = 1'b0;
    for (int j = 0; j < SLOTS; j++)
      if (q_valid[j] && q_rank[j] > q_rank[i]) q_rank[j]--;
  endtask

  // update the shadow queue and queue up the results one request causes
  task automatic apply_request(logic [1:0] req, logic [7:0] own, logic [2:0] knd,
                               logic [7:0] res, logic [31:0] dly);
    int expired;
    int free_slot;
    int rank;
    int best;
    int removed;
    expired = 0;
    free_slot = -1;
    rank = 0;
    best = -1;
    removed = 0;
    case (req)
      otq_pkg::REQ_TICK: begin
        for (int i = 0; i < SLOTS; i++)
          if (q_valid[i]) begin
            q_left[i]--;
            if (q_left[i] == 0) expired++;
          end
        for (int r = 0; r < expired; r++)
          for (int i = 0; i < SLOTS; i++)
            if (q_valid[i] && q_rank[i] == r) begin
              pending_q.push_back('{kind: otq_pkg::RK_EXPIRED, status: otq_pkg::ST_OK,
                                    owner: q_owner[i], tkind: q_kind[i],
                                    resource: q_res[i], removed: 5'd0,
                                    last: (r + 1 == expired)});
              q_valid[i] = 1'b0;
            end
        for (int i = 0; i < SLOTS; i++)
          if (q_valid[i]) q_rank[i] -= expired;
      end
      otq_pkg::REQ_SCHEDULE: begin
        if (dly == 0) dly = 32'd1;
        for (int i = SLOTS - 1; i >= 0; i--)
          if (!q_valid[i]) free_slot = i;
        if (free_slot < 0) begin
          pending_q.push_back('{otq_pkg::RK_SCHEDULE, otq_pkg::ST_FULL, 8'd0, 3'd0,
                                8'd0, 5'd0, 1'b1});
        end else begin
          // equal or earlier expiries stay ahead of the new entry
          for (int j = 0; j < SLOTS; j++)
            if (q_valid[j]) begin
              if (q_left[j] <= dly) rank++;
              else q_rank[j]++;
            end
          q_valid[free_slot] = 1'b1;
          q_owner[free_slot] = own;
          q_kind[free_slot] = knd;
          q_res[free_slot] = res;
          q_left[free_slot] = dly;
          q_rank[free_slot] = rank;
          pending_q.push_back('{otq_pkg::RK_SCHEDULE, otq_pkg::ST_OK, 8'd0, 3'd0,
                                8'd0, 5'd0, 1'b1});
        end
      end
      otq_pkg::REQ_CANCEL: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (q_valid[i] && q_owner[i] == own && q_kind[i] == knd &&
              !(knd == lock_code && q_res[i] != res))
            if (best < 0 || q_rank[i] < q_rank[best]) best = i;
        end
        if (best < 0) begin
          pending_q.push_back('{otq_pkg::RK_CANCEL, otq_pkg::ST_NOT_FOUND, 8'd0, 3'd0,
                                8'd0, 5'd0, 1'b1});
        end else begin
          drop_timer(best);
          pending_q.push_back('{otq_pkg::RK_CANCEL, otq_pkg::ST_OK, 8'd0, 3'd0,
                                8'd0, 5'd1, 1'b1});
        end
      end
      default: begin
        for (int i = 0; i < SLOTS; i++)
          if (q_valid[i] && q_owner[i] == own) begin
            drop_timer(i);
            removed++;
          end
        pending_q.push_back('{otq_pkg::RK_CANCEL,
                              (removed != 0) ? otq_pkg::ST_OK : otq_pkg::ST_NOT_FOUND,
                              8'd0, 3'd0, 8'd0,
                              (removed > 31) ? 5'd31 : 5'(removed), 1'b1});
      end
    endcase
  endtask

  // accept transactions, check results, watch for a hang
  int idle_cycles = 0;
  always @(posedge clk) begin
    otq_pkg::result_t got;
    otq_pkg::result_t want;
    int      mark;
    if (!rst) begin
      if (start && !busy) begin
        mark = pending_q.size();
        apply_request(req_type, owner_id, timeout_kind, resource_id, delay_ticks);
        if (pin_answer) begin
          while (pending_q.size() > mark) pending_q.pop_back();
          pending_q.push_back(pinned);
        end
        n_items++;
      end
      if (result_valid) begin
        got = '{result_kind, status, out_owner, out_kind, out_resource, removed_count, last};
        n_results++;
        if (result_kind == otq_pkg::RK_EXPIRED) n_expired++;
        if (result_kind == otq_pkg::RK_SCHEDULE && status == otq_pkg::ST_FULL) n_full++;
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected result, actual %p", $time, got);
          errors++;
        end else begin
          want = pending_q.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch, expected %p, actual %p", $time, want, got);
            errors++;
          end
        end
      end
      if ((start && !busy) || result_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // hand one transaction over, start stays high afterwards
  task automatic send(logic [1:0] req, logic [7:0] own, logic [2:0] knd,
                      logic [7:0] res, logic [31:0] dly, bit typed,
                      otq_pkg::result_t answer);
    req_type <= req;
    owner_id <= own;
    timeout_kind <= knd;
    resource_id <= res;
    delay_ticks <= dly;
    pin_answer <= typed;
    pinned <= answer;
    start <= 1'b1;
    // busy is stable at the falling edge; once low, the next rising edge accepts
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic pause_sender(int idle_pct);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  endtask

  // drain, then let the block settle before touching the register
  task automatic settle();
    start <= 1'b0;
    @(negedge clk);
    while (pending_q.size() != 0 || busy) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_lock_code(logic [2:0] code);
    lock_kind_we <= 1'b1;
    lock_kind_wdata <= code;
    lock_code = code;
    @(negedge clk);
    lock_kind_we <= 1'b0;
    @(negedge clk);
  endtask

  // random transaction, leaning on owners and entries already queued
  task automatic random_item(int idle_pct);
    int          pick;
    int          slot;
    logic [1:0]  req;
    logic [7:0]  own;
    logic [2:0]  knd;
    logic [7:0]  res;
    logic [31:0] dly;
    pick = $urandom_range(0, 99);
    own = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    knd = ($urandom_range(0, 1) == 0) ? lock_code : 3'($urandom);
    res = 8'($urandom_range(0, 3));
    if ($urandom_range(0, 3) == 0) res = 8'($urandom);
    case ($urandom_range(0, 9))
      0: dly = 32'd0;
      1: dly = $urandom;
      default: dly = $urandom_range(1, 8);
    endcase
    if (dly > 32'd100) own = 8'($urandom_range(0, 3));
    if (pick < 45) req = otq_pkg::REQ_SCHEDULE;
    else if (pick < 75) req = otq_pkg::REQ_TICK;
    else if (pick < 90) req = otq_pkg::REQ_CANCEL;
    else req = otq_pkg::REQ_CANCEL_ALL;
    if (req == otq_pkg::REQ_CANCEL && $urandom_range(0, 9) < 7) begin
      slot = $urandom_range(0, SLOTS - 1);
      if (q_valid[slot]) begin
        own = q_owner[slot];
        knd = q_kind[slot];
        res = ($urandom_range(0, 4) == 0) ? q_res[slot] ^ 8'h01 : q_res[slot];
      end
    end
    send(req, own, knd, res, dly, 1'b0, '0);
    pause_sender(idle_pct);
  endtask

  stim_row_t plan[$];

  function automatic stim_row_t row(logic [1:0] req, logic [7:0] own, logic [2:0] knd,
                                    logic [7:0] res, logic [31:0] dly, bit typed = 0,
                                    otq_pkg::result_t answer = '0);
    row = '{req, own, knd, res, dly, typed, answer};
  endfunction

  localparam otq_pkg::result_t SCHED_OK =
    '{otq_pkg::RK_SCHEDULE, otq_pkg::ST_OK, 8'd0, 3'd0, 8'd0, 5'd0, 1'b1};
  localparam otq_pkg::result_t SCHED_FULL =
    '{otq_pkg::RK_SCHEDULE, otq_pkg::ST_FULL, 8'd0, 3'd0, 8'd0, 5'd0, 1'b1};
  localparam otq_pkg::result_t CANCEL_NONE =
    '{otq_pkg::RK_CANCEL, otq_pkg::ST_NOT_FOUND, 8'd0, 3'd0, 8'd0, 5'd0, 1'b1};
  localparam otq_pkg::result_t CANCEL_ONE =
    '{otq_pkg::RK_CANCEL, otq_pkg::ST_OK, 8'd0, 3'd0, 8'd0, 5'd1, 1'b1};
  localparam otq_pkg::result_t CANCEL_TWO =
    '{otq_pkg::RK_CANCEL, otq_pkg::ST_OK, 8'd0, 3'd0, 8'd0, 5'd2, 1'b1};

  int idle_plan [4] = '{0, 73, 0, 20};

  initial begin
    for (int i = 0; i < SLOTS; i++) q_valid[i] = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty tick, extremes, zero delay, lock-kind matching, ties
    plan.push_back(row(otq_pkg::REQ_TICK, 8'd0, 3'd0, 8'd0, 32'd0));
    plan.push_back(row(otq_pkg::REQ_SCHEDULE, 8'hFF, 3'd7, 8'hFF, 32'hFFFF_FFFF, 1,
                       SCHED_OK));
    plan.push_back(row(otq_pkg::REQ_SCHEDULE, 8'd0, 3'd0, 8'd0, 32'd0, 1, SCHED_OK));
    plan.push_back(row(otq_pkg::REQ_SCHEDULE, 8'd1, 3'd1, 8'hAA, 32'd2));
    plan.push_back(row(otq_pkg::REQ_SCHEDULE, 8'd1, 3'd1, 8'h55, 32'd2));
    plan.push_back(row(otq_pkg::REQ_CANCEL, 8'd1, 3'd1, 8'h12, 32'd0, 1, CANCEL_NONE));
    plan.push_back(row(otq_pkg::REQ_CANCEL, 8'd1, 3'd1, 8'h55, 32'd0, 1, CANCEL_ONE));
    plan.push_back(row(otq_pkg::REQ_TICK, 8'd0, 3'd0, 8'd0, 32'd0));
    plan.push_back(row(otq_pkg::REQ_CANCEL, 8'd9, 3'd3, 8'd0, 32'd0, 1, CANCEL_NONE));
    plan.push_back(row(otq_pkg::REQ_CANCEL_ALL, 8'd77, 3'd0, 8'd0, 32'd0, 1,
                       CANCEL_NONE));
    plan.push_back(row(otq_pkg::REQ_TICK, 8'd0, 3'd0, 8'd0, 32'd0));
    plan.push_back(row(otq_pkg::REQ_SCHEDULE, 8'd2, 3'd2, 8'd3, 32'd3));
    plan.push_back(row(otq_pkg::REQ_SCHEDULE, 8'd3, 3'd2, 8'd3, 32'd3));
    plan.push_back(row(otq_pkg::REQ_SCHEDULE, 8'd4, 3'd5, 8'd6, 32'd3));
    plan.push_back(row(otq_pkg::REQ_SCHEDULE, 8'd2, 3'd4, 8'd0, 32'd1));
    plan.push_back(row(otq_pkg::REQ_CANCEL_ALL, 8'd2, 3'd0, 8'd0, 32'd0, 1, CANCEL_TWO));
    plan.push_back(row(otq_pkg::REQ_TICK, 8'd0, 3'd0, 8'd0, 32'd0));
    plan.push_back(row(otq_pkg::REQ_TICK, 8'd0, 3'd0, 8'd0, 32'd0));
    plan.push_back(row(otq_pkg::REQ_TICK, 8'd0, 3'd0, 8'd0, 32'd0));
    // fill every slot, then one schedule too many
    for (int i = 0; i < SLOTS - 1; i++)
      plan.push_back(row(otq_pkg::REQ_SCHEDULE, 8'(200 + i), 3'(i), 8'(i * 17),
                         32'($urandom_range(1, 3))));
    plan.push_back(row(otq_pkg::REQ_SCHEDULE, 8'd5, 3'd5, 8'd5, 32'd1, 1, SCHED_FULL));
    plan.push_back(row(otq_pkg::REQ_CANCEL_ALL, 8'hFF, 3'd0, 8'd0, 32'd0, 1, CANCEL_ONE));
    repeat (3) plan.push_back(row(otq_pkg::REQ_TICK, 8'd0, 3'd0, 8'd0, 32'd0));

    foreach (plan[k])
      send(plan[k].req, plan[k].owner, plan[k].kind, plan[k].res, plan[k].delay,
           plan[k].typed, plan[k].answer);
    pin_answer <= 1'b0;

    // random phases, each under its own lock code and sender idling
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: write_lock_code(3'd0);
        1: write_lock_code(3'd7);
        2: write_lock_code(3'($urandom));
        default: write_lock_code(3'd1);
      endcase
      repeat (30) random_item(idle_plan[ph]);
    end
    // tick out the short timeouts still queued
    repeat (10) begin
      send(otq_pkg::REQ_TICK, 8'd0, 3'd0, 8'd0, 32'd0, 1'b0, '0);
    end
    settle();

    if (pending_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_q.size());
      errors++;
    end
    $display("%0d transactions, %0d results checked (%0d expiries, %0d full answers)",
             n_items, n_results, n_expired, n_full);
    $display("lock code varied over 0, 7, random, 1; sender idling 0/73/0/20 percent");
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// ===== ordered_timer_queue_core.f =====
rtl/otq_pkg.sv
rtl/otq_ram.sv
rtl/ordered_timer_queue_core.sv
bench/tb_top.sv
